// ----- hw/rtl/mco_pkg.sv -----
// Shared types, screen constants and clipping helper for the midpoint circle outline block.
package mco_pkg;

  localparam int unsigned SCREEN_WIDTH  = 192;
  localparam int unsigned SCREEN_HEIGHT = 128;
  localparam int unsigned MAX_RADIUS    = 80;

  localparam int unsigned CoordW  = 10;
  localparam int unsigned OffsetW = 7;
  localparam int unsigned ColorW  = 4;
  localparam int unsigned DecW    = 9;
  localparam int unsigned SumW    = 12;
  localparam int unsigned WalkW   = 11;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_WALK
  } state_e;

  // True when a coordinate plus or minus an offset lands in [0, lim).
  function automatic logic in_range(logic [CoordW-1:0] c, logic [OffsetW-1:0] off,
                                    logic sub, logic [SumW-1:0] lim);
    logic [SumW-1:0] v;
    if (sub) begin
      v = {2'b00, c} - {5'b00000, off};
    end else begin
      v = {2'b00, c} + {5'b00000, off};
    end
    return !v[SumW-1] && (v < lim);
  endfunction

endpackage

// ----- hw/rtl/midpoint_circle_outline.sv -----
// Midpoint circle outline walker: one outline step per output transfer.
//
//  Channel  Dir  Handshake                  Payload
//  s_axis   in   s_axis_tvalid/tready       center_x, center_y, radius, draw_color
//  m_axis   out  m_axis_tvalid/tready       center, offsets, visible mask, color, tlast
//
// A command is taken in the idle state, then the walk gives one result per cycle
// while the output is not stalled, one for each minor offset from zero until it
// passes the major offset (57 for the largest radius). The single walk register
// set and its step adder set the rate; the next command is taken in the cycle
// after the final result is loaded.
// Reset clears the state machine, the stored color and the output valid.
// A stalled output holds the walk in place; a command is refused while walking.
module midpoint_circle_outline
  import mco_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // center_x[9:0], center_y[19:10], radius[26:20], draw_color[35:27], zero[39:36]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // center_x_out[9:0], center_y_out[19:10], offset_major[26:20],
  // offset_minor[33:27], visible_mask[41:34], pixel_color[45:42], zero[47:46]
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  state_e state_q, state_d;

  logic                     in_accept;
  logic                     step_en;
  logic [ColorW-1:0]        color_q;
  logic [CoordW-1:0]        cx_q, cy_q;
  logic [OffsetW-1:0]       major_q, minor_q;
  logic signed [DecW-1:0]   dec_q;

  logic [CoordW-1:0]        in_cx, in_cy;
  logic [OffsetW-1:0]       in_r, r_clamp;
  logic [8:0]               in_color;

  logic signed [WalkW-1:0]  minor_s, major_s, dec_ext, dec_n;
  logic                     last_n;
  logic [7:0]               mask;

  logic xpa, xma, xpb, xmb, ypa, yma, ypb, ymb;

  logic                     out_valid_q;
  logic [CoordW-1:0]        out_cx_q, out_cy_q;
  logic [OffsetW-1:0]       out_major_q, out_minor_q;
  logic [7:0]               out_mask_q;
  logic [ColorW-1:0]        out_color_q;
  logic                     out_last_q;

  assign in_cx    = s_axis_tdata[9:0];
  assign in_cy    = s_axis_tdata[19:10];
  assign in_r     = s_axis_tdata[26:20];
  assign in_color = s_axis_tdata[35:27];
  assign r_clamp  = (in_r > OffsetW'(MAX_RADIUS)) ? OffsetW'(MAX_RADIUS) : in_r;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (step_en && last_n) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    step_en       = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_WALK: step_en = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign in_accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    minor_s = WalkW'({4'b0000, minor_q}) + WalkW'(1);
    dec_ext = WalkW'(dec_q);
    if (dec_q[DecW-1]) begin
      major_s = WalkW'({4'b0000, major_q});
      dec_n   = dec_ext + (minor_s <<< 1) + WalkW'(1);
    end else begin
      major_s = WalkW'({4'b0000, major_q}) - WalkW'(1);
      dec_n   = dec_ext + ((minor_s - major_s) <<< 1) + WalkW'(1);
    end
    last_n = minor_s > major_s;
  end

  always_comb begin
    xpa = in_range(cx_q, major_q, 1'b0, SumW'(SCREEN_WIDTH));
    xma = in_range(cx_q, major_q, 1'b1, SumW'(SCREEN_WIDTH));
    xpb = in_range(cx_q, minor_q, 1'b0, SumW'(SCREEN_WIDTH));
    xmb = in_range(cx_q, minor_q, 1'b1, SumW'(SCREEN_WIDTH));
    ypa = in_range(cy_q, major_q, 1'b0, SumW'(SCREEN_HEIGHT));
    yma = in_range(cy_q, major_q, 1'b1, SumW'(SCREEN_HEIGHT));
    ypb = in_range(cy_q, minor_q, 1'b0, SumW'(SCREEN_HEIGHT));
    ymb = in_range(cy_q, minor_q, 1'b1, SumW'(SCREEN_HEIGHT));
    mask = {xpb & yma, xpa & ymb, xmb & yma, xma & ymb,
            xmb & ypa, xma & ypb, xpb & ypa, xpa & ypb};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      color_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept && !in_color[8]) color_q <= in_color[ColorW-1:0];
      if (step_en) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cx_q    <= in_cx;
      cy_q    <= in_cy;
      major_q <= r_clamp;
      minor_q <= '0;
      dec_q   <= DecW'(1) - DecW'({2'b00, r_clamp});
    end else if (step_en) begin
      major_q <= major_s[OffsetW-1:0];
      minor_q <= minor_s[OffsetW-1:0];
      dec_q   <= dec_n[DecW-1:0];
    end
    if (step_en) begin
      out_cx_q    <= cx_q;
      out_cy_q    <= cy_q;
      out_major_q <= major_q;
      out_minor_q <= minor_q;
      out_mask_q  <= mask;
      out_color_q <= color_q;
      out_last_q  <= last_n;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_color_q, out_mask_q, out_minor_q, out_major_q,
                          out_cy_q, out_cx_q};

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the midpoint circle outline walker.
module tb_top
  import mco_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_PER_PHASE = 80;
  localparam int unsigned SETTLE_CYCLES = 64;

  typedef struct packed {
    logic signed [8:0]  color;
    logic [OffsetW-1:0] radius;
    logic [CoordW-1:0]  cy;
    logic [CoordW-1:0]  cx;
  } circle_cmd_t;

  typedef struct packed {
    logic [CoordW-1:0]  cx;
    logic [CoordW-1:0]  cy;
    logic [OffsetW-1:0] major;
    logic [OffsetW-1:0] minor;
    logic [7:0]         mask;
    logic [ColorW-1:0]  color;
    logic               last;
  } outline_step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  circle_cmd_t   pending_cmds[$];
  outline_step_t outline_q[$];
  logic [ColorW-1:0] stored_color = '0;
  int unsigned   sender_idle_pct = 0;
  int unsigned   receiver_stall_pct = 0;
  int unsigned   hold_asked = 0;
  int unsigned   hold_granted = 0;
  int unsigned   hold_left = 0;
  int unsigned   cycle_count = 0;
  int unsigned   mismatches = 0;

  midpoint_circle_outline dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic logic on_screen(int px, int py);
    return px >= 0 && py >= 0 && px < int'(SCREEN_WIDTH) && py < int'(SCREEN_HEIGHT);
  endfunction

  function automatic void predict_outline(circle_cmd_t cmd);
    int r;
    int major;
    int minor;
    int decision;
    int cx;
    int cy;
    outline_step_t step;
    r = int'(cmd.radius);
    cx = int'(cmd.cx);
    cy = int'(cmd.cy);
    if (!cmd.color[8]) begin
      stored_color = cmd.color[ColorW-1:0];
    end
    if (r > int'(MAX_RADIUS)) begin
      r = int'(MAX_RADIUS);
    end
    major = r;
    minor = 0;
    decision = 1 - r;
    while (minor <= major) begin
      step.cx = cmd.cx;
      step.cy = cmd.cy;
      step.major = major[OffsetW-1:0];
      step.minor = minor[OffsetW-1:0];
      step.mask = {on_screen(cx + minor, cy - major), on_screen(cx + major, cy - minor),
                   on_screen(cx - minor, cy - major), on_screen(cx - major, cy - minor),
                   on_screen(cx - minor, cy + major), on_screen(cx - major, cy + minor),
                   on_screen(cx + minor, cy + major), on_screen(cx + major, cy + minor)};
      step.color = stored_color;
      minor = minor + 1;
      if (decision < 0) begin
        decision = decision + 2 * minor + 1;
      end else begin
        major = major - 1;
        decision = decision + 2 * (minor - major) + 1;
      end
      step.last = minor > major;
      outline_q.push_back(step);
    end
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : drive_commands
    circle_cmd_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_outline(circle_cmd_t'(s_axis_tdata[35:0]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = pending_cmds.pop_front();
          s_axis_tdata <= {4'b0000, nxt};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_granted) begin
      hold_left <= HOLD_CYCLES;
      hold_granted <= hold_asked;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch_outline
    outline_step_t exp_step;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (outline_q.size() == 0) begin
          $error("unexpected transfer on the result stream: tdata %h", m_axis_tdata);
          mismatches++;
        end else begin
          exp_step = outline_q.pop_front();
          check_field("center_x_out", exp_step.cx, m_axis_tdata[9:0]);
          check_field("center_y_out", exp_step.cy, m_axis_tdata[19:10]);
          check_field("offset_major", exp_step.major, m_axis_tdata[26:20]);
          check_field("offset_minor", exp_step.minor, m_axis_tdata[33:27]);
          check_field("visible_mask", exp_step.mask, m_axis_tdata[41:34]);
          check_field("pixel_color", exp_step.color, m_axis_tdata[45:42]);
          check_field("last", exp_step.last, m_axis_tlast);
        end
      end
      m_axis_tready <= hold_left == 0 && $urandom_range(99) >= receiver_stall_pct;
    end
  end

  task automatic add_cmd(int cx, int cy, int r, int color);
    circle_cmd_t cmd;
    cmd.cx = cx[CoordW-1:0];
    cmd.cy = cy[CoordW-1:0];
    cmd.radius = r[OffsetW-1:0];
    cmd.color = color[8:0];
    pending_cmds.push_back(cmd);
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (pending_cmds.size() != 0 || s_axis_tvalid || outline_q.size() != 0);
  endtask

  initial begin : stimulus
    int unsigned idle_modes[4][2] = '{'{0, 0}, '{74, 0}, '{0, 74}, '{31, 31}};
    int cx;
    int cy;
    int r;
    int color;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_cmd(0, 0, 0, -1);
    add_cmd(96, 64, 80, 5);
    add_cmd(96, 64, 127, -1);
    add_cmd(100, 60, 81, -256);
    add_cmd(1023, 1023, 1, 255);
    add_cmd(0, 1023, 10, 16);
    add_cmd(1023, 0, 2, -2);
    add_cmd(191, 127, 79, 15);
    add_cmd(192, 128, 5, 0);
    add_cmd(0, 0, 80, 170);
    add_cmd(10, 120, 20, -100);
    add_cmd(180, 5, 30, 85);
    add_cmd(96, 64, 0, 1);
    add_cmd(500, 300, 127, 254);
    add_cmd(96, 150, 40, -1);
    add_cmd(250, 64, 60, 7);
    add_cmd(40, 30, 3, 128);
    add_cmd(1, 1, 1, -255);
    wait_drained();

    foreach (idle_modes[m]) begin
      sender_idle_pct = idle_modes[m][0];
      receiver_stall_pct = idle_modes[m][1];
      if (m == 0) begin
        hold_asked++;
      end
      repeat (RANDOM_PER_PHASE) begin
        if ($urandom_range(99) < 85) begin
          cx = $urandom_range(SCREEN_WIDTH + 80);
          cy = $urandom_range(SCREEN_HEIGHT + 80);
        end else begin
          cx = $urandom_range(1023);
          cy = $urandom_range(1023);
        end
        case ($urandom_range(9))
          0: r = $urandom_range(127);
          1, 2: r = $urandom_range(MAX_RADIUS);
          default: r = $urandom_range(30);
        endcase
        color = $urandom_range(511);
        add_cmd(cx, cy, r, color);
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && outline_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mco_pkg.sv
hw/rtl/midpoint_circle_outline.sv
tb/tb_top.sv
